// File: rtl/chol_pkg.sv
// chol_pkg: shared types, constants and fixed-point helpers of the cholesky block
// used by chol_ctrl, chol_dp and cholesky_decomposition; no dependencies
`timescale 1ns / 1ps
package chol_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 24;
  localparam int MAX_SIZE_DEF = 8;
  localparam int CFG_W        = 4;
  localparam int FIELD_IDX_W  = 3;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]      row_index;
    logic [FIELD_IDX_W-1:0]      col_index;
    logic signed [WORD_BITS-1:0] entry_value;
    logic                        last_entry;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]      out_row;
    logic [FIELD_IDX_W-1:0]      out_col;
    logic signed [WORD_BITS-1:0] factor_value;
    logic                        not_positive_definite;
    logic                        last_result;
  } out_item_t;

  // controller to datapath strobes
  typedef struct packed {
    logic load;
    logic acc_clr;
    logic rd_li;
    logic rd_lk;
    logic mul;
    logic acc;
    logic rd_a;
    logic start_root;
    logic start_div;
    logic take_root;
    logic take_div;
    logic take_zero;
    logic wr_emit;
    logic err;
    logic last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic diff_le_zero;
    logic unit_busy;
    logic out_free;
  } status_t;

  // saturating add of two words
  function automatic logic signed [WORD_BITS-1:0] sat_add(
    input logic signed [WORD_BITS-1:0] a,
    input logic signed [WORD_BITS-1:0] b
  );
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_add = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_add = s[WORD_BITS-1:0];
    end
  endfunction

  // saturating subtract of two words
  function automatic logic signed [WORD_BITS-1:0] sat_sub(
    input logic signed [WORD_BITS-1:0] a,
    input logic signed [WORD_BITS-1:0] b
  );
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_sub = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_sub = s[WORD_BITS-1:0];
    end
  endfunction

  // magnitude of a word as unsigned
  function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] a);
    mag = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  endfunction

endpackage

// File: rtl/cholesky_decomposition.sv
// cholesky_decomposition: top level of the fixed-point cholesky factor block
// instantiates chol_ctrl and chol_dp; types and constants from chol_pkg
//
// usage:
//  - load the lower triangle on the input channel, one entry per request; an entry
//    above the diagonal or outside MAX_SIZE is dropped; last_entry starts the run
//  - matrix_size is written through cfg_we_i/cfg_wdata_i while the block is idle
//  - the factor comes out on the output channel in row-major lower-triangle order;
//    last_result marks its final entry, not_positive_definite flags a failed pivot
//  - in_stall_o is high from the last entry until the final result is registered
//  - each entry (i,k) runs a multiply-accumulate loop on the one factor memory read
//    port, then a diagonal square root (one bit a cycle) or an off-diagonal divide
//    (one quotient bit a cycle); the run time is set by the shared accumulate loop
//    and the serial units
//  - a stalled output holds its request; the sequencer waits at the next entry
//  - reset clears control and sets matrix_size to 8; memories are not cleared
`timescale 1ns / 1ps
module cholesky_decomposition #(
  parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  chol_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output chol_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [chol_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(MAX_SIZE);

  chol_pkg::cmd_t    cmd;
  chol_pkg::status_t status;
  logic [IW-1:0] idx_i, idx_k, idx_j;

  // sequencer
  chol_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_entry),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_i_o    (idx_i),
    .idx_k_o    (idx_k),
    .idx_j_o    (idx_j)
  );

  // arithmetic and storage
  chol_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .idx_i_i    (idx_i),
    .idx_k_i    (idx_k),
    .idx_j_i    (idx_j),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // failed pivot forces zero factor values
  a_npd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.not_positive_definite |-> out_data_o.factor_value == '0)
    else $error("nonzero factor after failed pivot");

  // results lie on or below the diagonal
  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_col <= out_data_o.out_row)
    else $error("result above diagonal");

  // the final result is a diagonal entry
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_result |-> out_data_o.out_row == out_data_o.out_col)
    else $error("last result off diagonal");

  // no serial unit runs while requests are taken
  a_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !status.unit_busy)
    else $error("unit busy while idle");
`endif

endmodule

// File: rtl/chol_ctrl.sv
// chol_ctrl: sequencer of the cholesky block, loop counters, pivot error, size register
// depends on chol_pkg; drives chol_dp through cmd_t and reads status_t
`timescale 1ns / 1ps
module chol_ctrl #(
  parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_stall_o,
  input  logic                        cfg_we_i,
  input  logic [chol_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  chol_pkg::status_t           status_i,
  output chol_pkg::cmd_t              cmd_o,
  output logic [$clog2(MAX_SIZE)-1:0] idx_i_o,
  output logic [$clog2(MAX_SIZE)-1:0] idx_k_o,
  output logic [$clog2(MAX_SIZE)-1:0] idx_j_o
);

  localparam int IW = $clog2(MAX_SIZE);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_RD_LI = 11'b00000000100,
    S_RD_LK = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_ACC   = 11'b00000100000,
    S_RD_A  = 11'b00001000000,
    S_DIFF  = 11'b00010000000,
    S_SQRT  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_WRITE = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] i_q, i_d, k_q, k_d, j_q, j_d;
  logic err_q, err_d;
  logic [chol_pkg::CFG_W-1:0] size_q;
  logic [IW-1:0] last_idx;
  logic entry_last;

  // last row index from the clamped size
  always_comb begin
    if (size_q == '0) begin
      last_idx = '0;
    end else if (int'(size_q) > MAX_SIZE) begin
      last_idx = IW'(MAX_SIZE - 1);
    end else begin
      last_idx = IW'(size_q - 1'b1);
    end
  end

  assign entry_last = (i_q == last_idx) && (k_q == i_q);
  assign in_stall_o = (state_q != S_IDLE);
  assign idx_i_o = i_q;
  assign idx_k_o = k_q;
  assign idx_j_o = j_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    i_d = i_q;
    k_d = k_q;
    j_d = j_q;
    err_d = err_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            i_d = '0;
            k_d = '0;
            err_d = 1'b0;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (err_q) begin
          cmd_o.take_zero = 1'b1;
          state_d = S_WRITE;
        end else begin
          cmd_o.acc_clr = 1'b1;
          j_d = '0;
          state_d = (k_q == '0) ? S_RD_A : S_RD_LI;
        end
      end
      S_RD_LI: begin
        cmd_o.rd_li = 1'b1;
        state_d = S_RD_LK;
      end
      S_RD_LK: begin
        cmd_o.rd_lk = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        j_d = IW'(j_q + 1'b1);
        state_d = (IW'(j_q + 1'b1) == k_q) ? S_RD_A : S_RD_LI;
      end
      S_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        if (i_q == k_q) begin
          if (status_i.diff_le_zero) begin
            err_d = 1'b1;
            cmd_o.take_zero = 1'b1;
            state_d = S_WRITE;
          end else begin
            cmd_o.start_root = 1'b1;
            state_d = S_SQRT;
          end
        end else begin
          cmd_o.start_div = 1'b1;
          state_d = S_DIV;
        end
      end
      S_SQRT: begin
        if (!status_i.unit_busy) begin
          cmd_o.take_root = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_DIV: begin
        if (!status_i.unit_busy) begin
          cmd_o.take_div = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.wr_emit = 1'b1;
          cmd_o.err = err_q;
          cmd_o.last = entry_last;
          if (entry_last) begin
            state_d = S_IDLE;
          end else if (k_q == i_q) begin
            i_d = IW'(i_q + 1'b1);
            k_d = '0;
            state_d = S_START;
          end else begin
            k_d = IW'(k_q + 1'b1);
            state_d = S_START;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      k_q <= '0;
      j_q <= '0;
      err_q <= 1'b0;
      size_q <= chol_pkg::SIZE_RESET;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      k_q <= k_d;
      j_q <= j_d;
      err_q <= err_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/chol_dp.sv
// chol_dp: matrix and factor memories, multiply-accumulate, square root and divide units
// depends on chol_pkg; sequenced by chol_ctrl, owns the output register
`timescale 1ns / 1ps
module chol_dp #(
  parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chol_pkg::in_item_t          in_data_i,
  input  chol_pkg::cmd_t              cmd_i,
  input  logic [$clog2(MAX_SIZE)-1:0] idx_i_i,
  input  logic [$clog2(MAX_SIZE)-1:0] idx_k_i,
  input  logic [$clog2(MAX_SIZE)-1:0] idx_j_i,
  output chol_pkg::status_t           status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output chol_pkg::out_item_t         out_data_o
);

  localparam int W     = chol_pkg::WORD_BITS;
  localparam int F     = chol_pkg::FRAC_BITS;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = (W + F) / 2;
  localparam int TW    = 2 * RB;
  localparam int NW    = W + F;
  localparam int CW    = $clog2(NW + 1);
  localparam int SW    = (RB > W) ? RB : W;

  logic signed [W-1:0] mat_mem [DEPTH];
  logic signed [W-1:0] fac_mem [DEPTH];

  logic signed [W-1:0] adata_q, fdata_q, opa_q, acc_q, vres_q;
  logic [2*W-1:0] prod_q;
  logic neg_q;
  logic [AW-1:0] in_addr, addr_ik, addr_ij, addr_kj, addr_kk, rd_addr;
  logic in_keep;

  logic [CW-1:0] cnt_q;
  logic div_mode_q;
  logic [TW-1:0] rad_q;
  logic [RB+1:0] rem_q, rem_n, trial;
  logic [RB-1:0] root_q;
  logic [NW-1:0] dq_q;
  logic [W:0] drem_q, drem_n;
  logic [W-1:0] dvs_q;
  logic dneg_q;

  logic [2*W:0] rnd, sh;
  logic signed [W-1:0] prod_fx, diff, root_val, div_val;
  logic [SW-1:0] root_ext;

  logic out_valid_q;
  chol_pkg::out_item_t out_q;

  // addresses
  assign in_addr = AW'(in_data_i.row_index) * AW'(MAX_SIZE) + AW'(in_data_i.col_index);
  assign addr_ik = AW'(idx_i_i) * AW'(MAX_SIZE) + AW'(idx_k_i);
  assign addr_ij = AW'(idx_i_i) * AW'(MAX_SIZE) + AW'(idx_j_i);
  assign addr_kj = AW'(idx_k_i) * AW'(MAX_SIZE) + AW'(idx_j_i);
  assign addr_kk = AW'(idx_k_i) * AW'(MAX_SIZE) + AW'(idx_k_i);
  assign in_keep = (in_data_i.col_index <= in_data_i.row_index) &&
                   (int'(in_data_i.row_index) < MAX_SIZE);

  always_comb begin
    if (cmd_i.rd_li) begin
      rd_addr = addr_ij;
    end else if (cmd_i.rd_lk) begin
      rd_addr = addr_kj;
    end else begin
      rd_addr = addr_kk;
    end
  end

  // matrix store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_keep) begin
      mat_mem[in_addr] <= in_data_i.entry_value;
    end
    if (cmd_i.rd_a) begin
      adata_q <= mat_mem[addr_ik];
    end
  end

  // factor store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_emit) begin
      fac_mem[addr_ik] <= vres_q;
    end
    if (cmd_i.rd_li || cmd_i.rd_lk || cmd_i.rd_a) begin
      fdata_q <= fac_mem[rd_addr];
    end
  end

  // product rounding to nearest, ties away, then saturation
  always_comb begin
    rnd = {1'b0, prod_q} + ((2*W+1)'(1) << (F - 1));
    sh = rnd >> F;
    if (sh > (2*W+1)'(chol_pkg::WORD_MAX)) begin
      prod_fx = neg_q ? chol_pkg::WORD_MIN : chol_pkg::WORD_MAX;
    end else begin
      prod_fx = neg_q ? -W'(sh) : W'(sh);
    end
  end

  assign diff = chol_pkg::sat_sub(adata_q, acc_q);

  // multiply-accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_lk) begin
      opa_q <= fdata_q;
    end
    if (cmd_i.mul) begin
      prod_q <= chol_pkg::mag(opa_q) * chol_pkg::mag(fdata_q);
      neg_q <= opa_q[W-1] ^ fdata_q[W-1];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= chol_pkg::sat_add(acc_q, prod_fx);
    end
  end

  // one root bit and one quotient bit per step
  always_comb begin
    rem_n = {rem_q[RB-1:0], rad_q[TW-1:TW-2]};
    trial = {root_q, 2'b01};
    drem_n = {drem_q[W-1:0], dq_q[NW-1]};
  end

  // iteration counter, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      div_mode_q <= 1'b0;
    end else if (cmd_i.start_root) begin
      cnt_q <= CW'(RB);
      div_mode_q <= 1'b0;
    end else if (cmd_i.start_div) begin
      cnt_q <= CW'(NW);
      div_mode_q <= 1'b1;
    end else if (cnt_q != '0) begin
      cnt_q <= CW'(cnt_q - 1'b1);
    end
  end

  // square root and divide registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_root) begin
      rad_q <= TW'(unsigned'(diff)) << F;
      rem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.start_div) begin
      dq_q <= NW'(chol_pkg::mag(diff)) << F;
      drem_q <= '0;
      dneg_q <= diff[W-1];
      dvs_q <= unsigned'(fdata_q);
    end else if (cnt_q != '0) begin
      if (div_mode_q) begin
        if (drem_n >= (W+1)'(dvs_q)) begin
          drem_q <= drem_n - (W+1)'(dvs_q);
          dq_q <= {dq_q[NW-2:0], 1'b1};
        end else begin
          drem_q <= drem_n;
          dq_q <= {dq_q[NW-2:0], 1'b0};
        end
      end else begin
        rad_q <= rad_q << 2;
        if (rem_n >= trial) begin
          rem_q <= rem_n - trial;
          root_q <= {root_q[RB-2:0], 1'b1};
        end else begin
          rem_q <= rem_n;
          root_q <= {root_q[RB-2:0], 1'b0};
        end
      end
    end
  end

  // saturate unit results to the word
  always_comb begin
    root_ext = SW'(root_q);
    if (root_ext > SW'(chol_pkg::WORD_MAX)) begin
      root_val = chol_pkg::WORD_MAX;
    end else begin
      root_val = W'(root_q);
    end
    if (dq_q > NW'(chol_pkg::WORD_MAX)) begin
      div_val = dneg_q ? chol_pkg::WORD_MIN : chol_pkg::WORD_MAX;
    end else begin
      div_val = dneg_q ? -W'(dq_q) : W'(dq_q);
    end
  end

  // entry value
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_zero) begin
      vres_q <= '0;
    end else if (cmd_i.take_root) begin
      vres_q <= root_val;
    end else if (cmd_i.take_div) begin
      vres_q <= div_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_emit) begin
      out_q.out_row <= chol_pkg::FIELD_IDX_W'(idx_i_i);
      out_q.out_col <= chol_pkg::FIELD_IDX_W'(idx_k_i);
      out_q.factor_value <= vres_q;
      out_q.not_positive_definite <= cmd_i.err;
      out_q.last_result <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign status_o.diff_le_zero = diff[W-1] || (diff == '0);
  assign status_o.unit_busy = (cnt_q != '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// File: test/tb.sv
// tb: self-checking testbench of the cholesky_decomposition fixed-point factor block
// loads lower triangles, predicts every factor entry in place and checks the output stream
// depends on chol_pkg and the cholesky_decomposition rtl
`timescale 1ns / 1ps
module tb;

  localparam int WORD_BITS   = chol_pkg::WORD_BITS;
  localparam int FRAC_BITS   = chol_pkg::FRAC_BITS;
  localparam int CFG_W       = chol_pkg::CFG_W;
  localparam int FIELD_IDX_W = chol_pkg::FIELD_IDX_W;
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = chol_pkg::WORD_MAX;
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = chol_pkg::WORD_MIN;
  localparam int N_MAX = 8;
  localparam logic signed [WORD_BITS-1:0] FX_ONE = WORD_BITS'(1) <<< FRAC_BITS;

  // matrix kinds of the random part
  typedef enum int {MK_DOMINANT, MK_TINY, MK_RAW, MK_NEG_PIVOT} matrix_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  chol_pkg::in_item_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  chol_pkg::out_item_t  out_data_o;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cholesky_decomposition u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic signed [WORD_BITS-1:0] a_mat [N_MAX*N_MAX];
  logic signed [WORD_BITS-1:0] l_mat [N_MAX*N_MAX];
  bit                          entry_written [N_MAX*N_MAX];
  bit                          pivot_failed;
  logic [CFG_W-1:0]            size_reg;
  chol_pkg::out_item_t         expected_factors[$];

  int  n_fail;
  int  n_requests;
  int  n_factors;
  int  n_runs;
  int  n_pivot_fail_runs;
  bit  idle_on;
  bit  valid_up;
  int  stall_left;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // fixed-point helpers of the predictor
  function automatic logic signed [WORD_BITS-1:0] clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return v[WORD_BITS-1:0];
  endfunction

  function automatic longint unsigned abs_word(input logic signed [WORD_BITS-1:0] a);
    longint s;
    s = a;
    return (s < 0) ? longint'(-s) : s;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] signed_from_mag(
    input bit neg, input longint unsigned m);
    if (m > longint'(WORD_MAX)) return neg ? WORD_MIN : WORD_MAX;
    return neg ? WORD_BITS'(-longint'(m)) : WORD_BITS'(m);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] fx_product(
    input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
    longint unsigned p;
    p = abs_word(a) * abs_word(b);
    p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return signed_from_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1], p);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] fx_root(input logic signed [WORD_BITS-1:0] a);
    longint unsigned t, r, c;
    t = longint'(a) << FRAC_BITS;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= t) r = c;
    end
    return signed_from_mag(1'b0, r);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] fx_quotient(
    input logic signed [WORD_BITS-1:0] num, input logic signed [WORD_BITS-1:0] d);
    longint unsigned q;
    if (d == 0) begin
      if (num > 0) return WORD_MAX;
      if (num < 0) return WORD_MIN;
      return '0;
    end
    q = (abs_word(num) << FRAC_BITS) / abs_word(d);
    return signed_from_mag(num[WORD_BITS-1] ^ d[WORD_BITS-1], q);
  endfunction

  // store one accepted request and, on the last entry, predict the whole factor
  task automatic factor_predict(input chol_pkg::in_item_t it);
    int n;
    logic signed [WORD_BITS-1:0] acc, arg, v;
    chol_pkg::out_item_t o;
    if (it.col_index <= it.row_index) begin
      a_mat[it.row_index*N_MAX + it.col_index] = it.entry_value;
      entry_written[it.row_index*N_MAX + it.col_index] = 1'b1;
    end
    if (!it.last_entry) return;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > N_MAX) n = N_MAX;
    pivot_failed = 1'b0;
    n_runs++;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k <= i; k++) begin
        v = '0;
        if (!pivot_failed) begin
          acc = '0;
          for (int j = 0; j < k; j++)
            acc = clamp_word(longint'(acc) +
                             longint'(fx_product(l_mat[i*N_MAX+j], l_mat[k*N_MAX+j])));
          if (i == k) begin
            arg = clamp_word(longint'(a_mat[i*N_MAX+i]) - longint'(acc));
            if (arg <= 0) pivot_failed = 1'b1;
            else v = fx_root(arg);
          end else begin
            arg = clamp_word(longint'(a_mat[i*N_MAX+k]) - longint'(acc));
            v = fx_quotient(arg, l_mat[k*N_MAX+k]);
          end
        end
        l_mat[i*N_MAX+k] = v;
        o.out_row               = FIELD_IDX_W'(i);
        o.out_col               = FIELD_IDX_W'(k);
        o.factor_value          = v;
        o.not_positive_definite = pivot_failed;
        o.last_result           = (i == n - 1) && (k == i);
        expected_factors.push_back(o);
      end
    end
    if (pivot_failed) n_pivot_fail_runs++;
  endtask

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // output stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  = pick_gap();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    chol_pkg::out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_factors++;
      if (expected_factors.size() == 0) begin
        $error("unexpected factor entry row %0d col %0d", out_data_o.out_row,
               out_data_o.out_col);
        n_fail++;
      end else begin
        e = expected_factors.pop_front();
        if (out_data_o.out_row !== e.out_row) begin
          $error("out_row: expected %0d actual %0d", e.out_row, out_data_o.out_row);
          n_fail++;
        end
        if (out_data_o.out_col !== e.out_col) begin
          $error("out_col: expected %0d actual %0d", e.out_col, out_data_o.out_col);
          n_fail++;
        end
        if (out_data_o.factor_value !== e.factor_value) begin
          $error("factor_value (%0d,%0d): expected %h actual %h", e.out_row, e.out_col,
                 e.factor_value, out_data_o.factor_value);
          n_fail++;
        end
        if (out_data_o.not_positive_definite !== e.not_positive_definite) begin
          $error("not_positive_definite: expected %0b actual %0b",
                 e.not_positive_definite, out_data_o.not_positive_definite);
          n_fail++;
        end
        if (out_data_o.last_result !== e.last_result) begin
          $error("last_result: expected %0b actual %0b", e.last_result,
                 out_data_o.last_result);
          n_fail++;
        end
      end
    end
  end

  // send one request and wait for its acceptance
  task automatic send_entry(input int row, input int col,
                            input logic signed [WORD_BITS-1:0] val, input bit last);
    chol_pkg::in_item_t it;
    int gap;
    it.row_index   = FIELD_IDX_W'(row);
    it.col_index   = FIELD_IDX_W'(col);
    it.entry_value = val;
    it.last_entry  = last;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    valid_up = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    factor_predict(it);
    n_requests++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and wait until every predicted factor entry has come out
  task automatic drain();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    size_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic int used_size();
    if (size_reg < 1) return 1;
    if (size_reg > N_MAX) return N_MAX;
    return size_reg;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] pick_value(
    input matrix_kind_e kind, input bit diag, input int n);
    case (kind)
      MK_DOMINANT: begin
        if (diag) return WORD_BITS'(n) * FX_ONE + $urandom_range(FX_ONE * 4);
        return $signed($urandom_range(2 * FX_ONE)) - FX_ONE;
      end
      MK_TINY: begin
        if (diag) return $urandom_range(32'h0010_0000, 32'h0000_1000);
        return $signed($urandom_range(32'h0000_1000)) - 32'sh800;
      end
      MK_NEG_PIVOT: begin
        if (diag) return $signed($urandom_range(2 * FX_ONE)) - FX_ONE;
        return $signed($urandom_range(4 * FX_ONE)) - 2 * FX_ONE;
      end
      default: return $urandom();
    endcase
  endfunction

  // send a full lower triangle of the current size in shuffled order, with noise
  task automatic send_matrix(input matrix_kind_e kind);
    int n, idx, pick, cnt;
    bit run_started;
    int cells[$];
    n = used_size();
    run_started = 1'b0;
    for (int i = 0; i < N_MAX; i++)
      for (int k = 0; k <= i; k++)
        if (i < n || $urandom_range(9) == 0) cells.push_back(i*N_MAX + k);
    cells.shuffle();
    cnt = cells.size();
    for (idx = 0; idx < cnt; idx++) begin
      pick = cells[idx];
      // occasional upper-triangle request that the block drops
      if ($urandom_range(11) == 0)
        send_entry($urandom_range(6), $urandom_range(7, 7), $urandom(), 1'b0);
      run_started = (idx == cnt - 1) && ($urandom_range(3) != 0);
      send_entry(pick / N_MAX, pick % N_MAX,
                 pick_value(kind, (pick / N_MAX) == (pick % N_MAX), n), run_started);
    end
    // otherwise the start comes on a dropped upper entry
    if (!run_started) send_entry(2, 5, $urandom(), 1'b1);
  endtask

  // a rerun that rewrites a few entries only; everything needed is already written
  task automatic send_partial(input matrix_kind_e kind);
    int n, cnt, i, k;
    n = used_size();
    cnt = $urandom_range(3, 1);
    for (int m = 0; m < cnt; m++) begin
      i = $urandom_range(n - 1);
      k = $urandom_range(i);
      send_entry(i, k, pick_value(kind, i == k, n), m == cnt - 1);
    end
  endtask

  function automatic bit triangle_ready();
    int n;
    n = used_size();
    for (int i = 0; i < n; i++)
      for (int k = 0; k <= i; k++)
        if (!entry_written[i*N_MAX + k]) return 1'b0;
    return 1'b1;
  endfunction

  // one-by-one matrices: extreme values, zero and negative pivots, size zero
  task automatic test_single_entry();
    write_size(4'd1);
    send_entry(0, 0, WORD_MAX, 1'b1);
    send_entry(0, 0, 32'sd1, 1'b1);
    send_entry(0, 0, '0, 1'b1);
    write_size(4'd0);
    send_entry(0, 0, WORD_MIN, 1'b1);
    send_entry(0, 0, FX_ONE, 1'b1);
  endtask

  // two-by-two: quotient saturation, failing second pivot, dropped requests
  task automatic test_two_by_two();
    write_size(4'd2);
    send_entry(0, 0, 32'sd1, 1'b0);
    send_entry(1, 0, WORD_MAX, 1'b0);
    send_entry(1, 1, WORD_MAX, 1'b1);
    send_entry(1, 0, WORD_MIN, 1'b0);
    send_entry(1, 1, WORD_MIN, 1'b1);
    send_entry(0, 0, 4 * FX_ONE, 1'b0);
    send_entry(0, 7, WORD_MAX, 1'b0);
    send_entry(1, 0, 2 * FX_ONE, 1'b0);
    send_entry(1, 1, 5 * FX_ONE, 1'b0);
    send_entry(3, 4, '0, 1'b1);
    send_entry(7, 7, -FX_ONE, 1'b0);
    send_entry(1, 1, FX_ONE, 1'b1);
  endtask

  // random part: mostly well-formed matrices over all sizes, some broken ones
  task automatic test_random_matrices();
    matrix_kind_e kind;
    int r, start;
    start = n_requests;
    write_size(4'd15);
    send_matrix(MK_DOMINANT);
    write_size(4'd8);
    send_matrix(MK_DOMINANT);
    while (n_requests - start < 105) begin
      idle_on = ($urandom_range(4) != 0);
      if ($urandom_range(2) == 0) write_size(CFG_W'($urandom_range(15)));
      r = $urandom_range(99);
      kind = (r < 60) ? MK_DOMINANT : (r < 75) ? MK_TINY : (r < 88) ? MK_RAW : MK_NEG_PIVOT;
      if (triangle_ready() && $urandom_range(3) == 0) send_partial(kind);
      else send_matrix(kind);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    clk_i       = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    n_fail = 0; n_requests = 0; n_factors = 0; n_runs = 0; n_pivot_fail_runs = 0;
    idle_on = 1'b1; valid_up = 1'b0;
    pivot_failed = 1'b0;
    size_reg = chol_pkg::SIZE_RESET;
    for (int m = 0; m < N_MAX*N_MAX; m++) begin
      a_mat[m] = '0;
      l_mat[m] = '0;
      entry_written[m] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_entry();
    test_two_by_two();
    test_random_matrices();

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d requests, %0d decompositions (%0d not positive definite),",
             n_requests, n_runs, n_pivot_fail_runs);
    $display("%0d factor entries checked over sizes 0 to 15", n_factors);
    if (n_fail == 0 && expected_factors.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
